### rtl/bcp_pkg.sv
// shared types, constants and fixed-point helpers for the point projection block
package bcp_pkg;

   // image size defaults in whole pixels
   localparam int IMAGE_WIDTH_DEF  = 1920;
   localparam int IMAGE_HEIGHT_DEF = 1080;

   // divider pipeline: two quotient bits per stage
   localparam int DIV_STAGES = 16;

   // csr port geometry (one register every 8 bytes, 64-bit data)
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   // register indexes
   localparam logic [2:0] REG_FOCAL_X    = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y    = 3'd1;
   localparam logic [2:0] REG_CENTER_X   = 3'd2;
   localparam logic [2:0] REG_CENTER_Y   = 3'd3;
   localparam logic [2:0] REG_RADIAL_K1  = 3'd4;
   localparam logic [2:0] REG_RADIAL_K2  = 3'd5;
   localparam logic [2:0] REG_RADIAL_K3  = 3'd6;
   localparam logic [2:0] REG_TANGENTIAL = 3'd7;

   // register reset values
   localparam logic [31:0] FOCAL_X_RST  = 32'd65536000;
   localparam logic [31:0] FOCAL_Y_RST  = 32'd65536000;
   localparam logic [31:0] CENTER_X_RST = 32'd62914560;
   localparam logic [31:0] CENTER_Y_RST = 32'd35389440;

   // fixed-point constants
   localparam logic signed [31:0] Q24_ONE  = 32'sd16777216;
   localparam logic signed [63:0] Q24_HALF = 64'sd8388608;
   localparam logic signed [39:0] S32_MAX  = 40'sd2147483647;
   localparam logic signed [39:0] S32_MIN  = -40'sd2147483648;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [31:0]        focal_x;
      logic [31:0]        focal_y;
      logic [31:0]        center_x;
      logic [31:0]        center_y;
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } cfg_type;

   // saturated Q8.24 value with its overflow flag
   typedef struct packed {
      logic               ovf;
      logic signed [31:0] val;
   } qv_type;

   // saturate a wide value to signed 32 bits
   function automatic qv_type sat_wide(input logic signed [39:0] s);
      qv_type r;
      if (s > S32_MAX) begin
         r.ovf = 1'b1;
         r.val = 32'sh7fffffff;
      end else if (s < S32_MIN) begin
         r.ovf = 1'b1;
         r.val = 32'sh80000000;
      end else begin
         r.ovf = 1'b0;
         r.val = s[31:0];
      end
      return r;
   endfunction

   // round a Q16.48 product to Q8.24, ties up, then saturate
   function automatic qv_type q_round(input logic signed [63:0] p);
      logic signed [63:0] t;
      logic signed [63:0] s;
      t = p + Q24_HALF;
      s = t >>> 24;
      return sat_wide(s[39:0]);
   endfunction

   // saturating add
   function automatic qv_type q_add(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [39:0] s;
      s = 40'(a) + 40'(b);
      return sat_wide(s);
   endfunction

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [32:0] div_step(input logic [31:0] rem, input logic b,
                                            input logic [31:0] d);
      logic [32:0] t;
      t = {rem, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         return {1'b1, t[31:0]};
      end
      return {1'b0, t[31:0]};
   endfunction

   // dividend bit for quotient bit i: |X| sits at bits 31..24 below the remainder
   function automatic logic div_bit(input logic [7:0] low, input int i);
      if (i >= 24) begin
         return low[3'(i - 24)];
      end
      return 1'b0;
   endfunction

endpackage

### rtl/brown_conrady_point_projection.sv
// top level: request skid, divider, distortion pipeline and csr block
//
//   channel   ports                               direction
//   request   req_valid/req_stall, req_cam_x/y/z  in
//   response  rsp_valid/rsp_stall, rsp_pixel_*    out
//   csr       csr_psel ... csr_pready             apb slave
//
// one request per cycle sustained while the response is not stalled; 30 register stages
// lie between the accepting edge and rsp_valid
// the stages are the 16 divider stages (two quotient bits each) plus prep and sign
// stages, and six multiply/round stage pairs for the polynomial and focal mapping
// synchronous reset clears valid bits and loads csr reset values
// rsp_stall on a valid response freezes the whole pipeline; a request taken in that
// cycle lands in a skid register and req_stall is that register's full flag
module brown_conrady_point_projection import bcp_pkg::*; #(
   parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_cam_x,
   input  logic signed [31:0] req_cam_y,
   input  logic signed [31:0] req_cam_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [27:0]        rsp_pixel_u,
   output logic [27:0]        rsp_pixel_v,
   output logic               rsp_in_image,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam logic [27:0] U_MAX = 28'(IMAGE_WIDTH * 65536 - 1);

   cfg_type            cfg;
   logic               pipe_en;
   logic               req_acc;
   logic               skid_valid_ff, skid_valid_in;
   logic signed [31:0] skid_x_ff, skid_y_ff, skid_z_ff;
   logic               src_valid;
   logic signed [31:0] src_x, src_y, src_z;
   logic               dv_valid, dv_bad;
   logic signed [31:0] dv_x, dv_y;

   // csr block
   bcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // pipeline advances unless the response is held
   assign pipe_en   = !(rsp_valid && rsp_stall);
   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !skid_valid_ff;

   // request source: skid first, else the port
   assign src_valid = skid_valid_ff || req_valid;
   assign src_x     = skid_valid_ff ? skid_x_ff : req_cam_x;
   assign src_y     = skid_valid_ff ? skid_y_ff : req_cam_y;
   assign src_z     = skid_valid_ff ? skid_z_ff : req_cam_z;

   // skid register
   always_comb begin
      if (pipe_en) begin
         skid_valid_in = 1'b0;
      end else begin
         skid_valid_in = skid_valid_ff || req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && !pipe_en) begin
         skid_x_ff <= req_cam_x;
         skid_y_ff <= req_cam_y;
         skid_z_ff <= req_cam_z;
      end
   end

   // perspective divide
   bcp_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (src_valid),
      .in_x      (src_x),
      .in_y      (src_y),
      .in_z      (src_z),
      .out_valid (dv_valid),
      .out_x     (dv_x),
      .out_y     (dv_y),
      .out_bad   (dv_bad)
   );

   // distortion and pixel mapping
   bcp_distort #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .en           (pipe_en),
      .cfg          (cfg),
      .in_valid     (dv_valid),
      .in_x         (dv_x),
      .in_y         (dv_y),
      .in_bad       (dv_bad),
      .out_valid    (rsp_valid),
      .out_u        (rsp_pixel_u),
      .out_v        (rsp_pixel_v),
      .out_in_image (rsp_in_image)
   );

`ifndef SYNTH
   // a request taken while the pipeline is held must land in the skid
   a_skid_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !pipe_en) |=> skid_valid_ff)
      else $error("request taken during hold was not kept in skid");

   // the skid drains as soon as the pipeline moves
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pipe_en) |=> !skid_valid_ff)
      else $error("skid did not drain");

   // off-image responses carry zero coordinates
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_image) |-> (rsp_pixel_u == 28'd0 && rsp_pixel_v == 28'd0))
      else $error("invalid pixel has nonzero coordinates");

   // in-image responses stay within the width
   a_u_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_image) |-> (rsp_pixel_u <= U_MAX))
      else $error("pixel_u beyond image width");
`endif

endmodule

### rtl/bcp_csr.sv
// configuration registers behind the csr port
module bcp_csr import bcp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [2:0] idx;
   logic       wr;
   cfg_type    cfg_ff;

   assign idx        = csr_paddr[5:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x  <= FOCAL_X_RST;
         cfg_ff.focal_y  <= FOCAL_Y_RST;
         cfg_ff.center_x <= CENTER_X_RST;
         cfg_ff.center_y <= CENTER_Y_RST;
         cfg_ff.k1       <= '0;
         cfg_ff.k2       <= '0;
         cfg_ff.k3       <= '0;
         cfg_ff.p1       <= '0;
         cfg_ff.p2       <= '0;
      end else if (wr) begin
         case (idx)
            REG_FOCAL_X:    cfg_ff.focal_x  <= csr_pwdata[31:0];
            REG_FOCAL_Y:    cfg_ff.focal_y  <= csr_pwdata[31:0];
            REG_CENTER_X:   cfg_ff.center_x <= csr_pwdata[31:0];
            REG_CENTER_Y:   cfg_ff.center_y <= csr_pwdata[31:0];
            REG_RADIAL_K1:  cfg_ff.k1       <= csr_pwdata[31:0];
            REG_RADIAL_K2:  cfg_ff.k2       <= csr_pwdata[31:0];
            REG_RADIAL_K3:  cfg_ff.k3       <= csr_pwdata[31:0];
            REG_TANGENTIAL: begin
               cfg_ff.p1 <= csr_pwdata[31:0];
               cfg_ff.p2 <= csr_pwdata[63:32];
            end
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_FOCAL_X:    csr_prdata = {32'd0, cfg_ff.focal_x};
         REG_FOCAL_Y:    csr_prdata = {32'd0, cfg_ff.focal_y};
         REG_CENTER_X:   csr_prdata = {32'd0, cfg_ff.center_x};
         REG_CENTER_Y:   csr_prdata = {32'd0, cfg_ff.center_y};
         REG_RADIAL_K1:  csr_prdata = {32'd0, cfg_ff.k1};
         REG_RADIAL_K2:  csr_prdata = {32'd0, cfg_ff.k2};
         REG_RADIAL_K3:  csr_prdata = {32'd0, cfg_ff.k3};
         REG_TANGENTIAL: csr_prdata = {cfg_ff.p2, cfg_ff.p1};
         default:        csr_prdata = '0;
      endcase
   end

endmodule

### rtl/bcp_divider.sv
// pipelined restoring divider producing x = X/Z and y = Y/Z in Q8.24
module bcp_divider import bcp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic signed [31:0] in_z,
   output logic               out_valid,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y,
   output logic               out_bad
);

   localparam int NSTG = DIV_STAGES;

   logic [NSTG:0]  v_ff;
   logic [31:0]    rx_ff [0:NSTG];
   logic [31:0]    ry_ff [0:NSTG];
   logic [31:0]    qx_ff [0:NSTG];
   logic [31:0]    qy_ff [0:NSTG];
   logic [31:0]    d_ff  [0:NSTG];
   logic [7:0]     lx_ff [0:NSTG];
   logic [7:0]     ly_ff [0:NSTG];
   logic [NSTG:0]  nx_ff;
   logic [NSTG:0]  ny_ff;
   logic [NSTG:0]  bad_ff;

   logic [31:0]    rx_in [1:NSTG];
   logic [31:0]    ry_in [1:NSTG];
   logic [31:0]    qx_in [1:NSTG];
   logic [31:0]    qy_in [1:NSTG];

   logic [31:0]    ax, ay, az;
   logic           bad_in;

   logic               ov_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic               ox_ovf, oy_ovf;
   logic signed [31:0] ox_in, oy_in;

   // magnitudes and the early overflow test (quotient of 2^32 or more, or zero depth)
   always_comb begin
      ax = in_x[31] ? 32'(-in_x) : in_x;
      ay = in_y[31] ? 32'(-in_y) : in_y;
      az = in_z[31] ? 32'(-in_z) : in_z;
      bad_in = ({8'd0, ax} >= {az, 8'd0}) || ({8'd0, ay} >= {az, 8'd0});
   end

   // two quotient bits per stage
   always_comb begin
      logic [32:0] sa, sb;
      for (int s = 0; s < NSTG; s++) begin
         sa = div_step(rx_ff[s], div_bit(lx_ff[s], 31 - 2 * s), d_ff[s]);
         sb = div_step(sa[31:0], div_bit(lx_ff[s], 30 - 2 * s), d_ff[s]);
         rx_in[s+1] = sb[31:0];
         qx_in[s+1] = {qx_ff[s][29:0], sa[32], sb[32]};
         sa = div_step(ry_ff[s], div_bit(ly_ff[s], 31 - 2 * s), d_ff[s]);
         sb = div_step(sa[31:0], div_bit(ly_ff[s], 30 - 2 * s), d_ff[s]);
         ry_in[s+1] = sb[31:0];
         qy_in[s+1] = {qy_ff[s][29:0], sa[32], sb[32]};
      end
   end

   // apply signs and flag results beyond signed 32 bits as bad
   always_comb begin
      if (nx_ff[NSTG]) begin
         ox_ovf = qx_ff[NSTG] > 32'h80000000;
         ox_in  = 32'(-qx_ff[NSTG]);
      end else begin
         ox_ovf = qx_ff[NSTG][31];
         ox_in  = qx_ff[NSTG];
      end
      if (ny_ff[NSTG]) begin
         oy_ovf = qy_ff[NSTG] > 32'h80000000;
         oy_in  = 32'(-qy_ff[NSTG]);
      end else begin
         oy_ovf = qy_ff[NSTG][31];
         oy_in  = qy_ff[NSTG];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[NSTG-1:0], in_valid};
         ov_ff <= v_ff[NSTG];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0]  <= {8'd0, ax[31:8]};
         ry_ff[0]  <= {8'd0, ay[31:8]};
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
         d_ff[0]   <= az;
         lx_ff[0]  <= ax[7:0];
         ly_ff[0]  <= ay[7:0];
         nx_ff[0]  <= in_x[31] ^ in_z[31];
         ny_ff[0]  <= in_y[31] ^ in_z[31];
         bad_ff[0] <= bad_in;
         for (int s = 1; s <= NSTG; s++) begin
            rx_ff[s]  <= rx_in[s];
            ry_ff[s]  <= ry_in[s];
            qx_ff[s]  <= qx_in[s];
            qy_ff[s]  <= qy_in[s];
            d_ff[s]   <= d_ff[s-1];
            lx_ff[s]  <= lx_ff[s-1];
            ly_ff[s]  <= ly_ff[s-1];
            nx_ff[s]  <= nx_ff[s-1];
            ny_ff[s]  <= ny_ff[s-1];
            bad_ff[s] <= bad_ff[s-1];
         end
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         out_bad <= bad_ff[NSTG] | ox_ovf | oy_ovf;
      end
   end

   assign out_valid = ov_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;

endmodule

### rtl/bcp_distort.sv
// distortion polynomial, focal mapping and bounds check, one multiply level per stage pair
module bcp_distort import bcp_pkg::*; #(
   parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic               in_bad,
   output logic               out_valid,
   output logic [27:0]        out_u,
   output logic [27:0]        out_v,
   output logic               out_in_image
);

   localparam logic signed [41:0] U_LIM = 42'(IMAGE_WIDTH * 65536);
   localparam logic signed [41:0] V_LIM = 42'(IMAGE_HEIGHT * 65536);

   logic [11:0] v_ff;
   logic [11:1] b_ff;

   // stage 1: squares and cross product
   logic signed [31:0] x1_ff, y1_ff;
   logic signed [63:0] pxx1_ff, pyy1_ff, pxy1_ff;
   // stage 2: r2 and doubled terms
   logic signed [31:0] x2_ff, y2_ff, r2_2_ff, xyd2_ff, xxd2_ff, yyd2_ff;
   qv_type             xx2, yy2, xy2, r2_2_in, xyd2_in, xxd2_in, yyd2_in;
   logic               b2_in;
   // stage 3: r4, k1*r2, tangential sums
   logic signed [31:0] x3_ff, y3_ff, r2_3_ff, xyd3_ff, tx3_ff, ty3_ff;
   logic signed [63:0] pr4_3_ff, pk1_3_ff;
   qv_type             tx3_in, ty3_in;
   logic               b3_in;
   // stage 4: first radial sum
   logic signed [31:0] x4_ff, y4_ff, r2_4_ff, r4_4_ff, xyd4_ff, tx4_ff, ty4_ff, a1_4_ff;
   qv_type             r4_4_in, k1r2_4, a1_4_in;
   logic               b4_in;
   // stage 5: r6 and k2*r4
   logic signed [31:0] x5_ff, y5_ff, xyd5_ff, tx5_ff, ty5_ff, a1_5_ff;
   logic signed [63:0] pr6_5_ff, pk2_5_ff;
   // stage 6: second radial sum
   logic signed [31:0] x6_ff, y6_ff, xyd6_ff, tx6_ff, ty6_ff, a2_6_ff, r6_6_ff;
   qv_type             r6_6_in, k2r4_6, a2_6_in;
   logic               b6_in;
   // stage 7: k3*r6 and tangential products
   logic signed [31:0] x7_ff, y7_ff, a2_7_ff;
   logic signed [63:0] pk3_7_ff, pxa7_ff, pxb7_ff, pya7_ff, pyb7_ff;
   // stage 8: radial factor and rounded tangential terms
   logic signed [31:0] x8_ff, y8_ff, rad8_ff, txa8_ff, txb8_ff, tya8_ff, tyb8_ff;
   qv_type             k3r6_8, rad8_in, txa8_in, txb8_in, tya8_in, tyb8_in;
   logic               b8_in;
   // stage 9: x*rad, y*rad
   logic signed [63:0] px9_ff, py9_ff;
   logic signed [31:0] txa9_ff, txb9_ff, tya9_ff, tyb9_ff;
   // stage 10: distorted coordinates
   logic signed [31:0] xd10_ff, yd10_ff;
   qv_type             xr10, yr10, xs10, ys10, xd10_in, yd10_in;
   logic               b10_in;
   // stage 11: focal products
   logic signed [64:0] pu11_ff, pv11_ff;
   // stage 12: pixel result
   logic signed [64:0] tu, tv;
   logic signed [41:0] u12, v12;
   logic               in12;
   logic [27:0]        u12_ff, v12_ff;
   logic               in12_ff;

   // rounding and saturating adds between multiplier levels
   always_comb begin
      xx2     = q_round(pxx1_ff);
      yy2     = q_round(pyy1_ff);
      xy2     = q_round(pxy1_ff);
      r2_2_in = q_add(xx2.val, yy2.val);
      xyd2_in = q_add(xy2.val, xy2.val);
      xxd2_in = q_add(xx2.val, xx2.val);
      yyd2_in = q_add(yy2.val, yy2.val);
      b2_in   = b_ff[1] | xx2.ovf | yy2.ovf | xy2.ovf | r2_2_in.ovf | xyd2_in.ovf
              | xxd2_in.ovf | yyd2_in.ovf;

      tx3_in = q_add(r2_2_ff, xxd2_ff);
      ty3_in = q_add(r2_2_ff, yyd2_ff);
      b3_in  = b_ff[2] | tx3_in.ovf | ty3_in.ovf;

      r4_4_in = q_round(pr4_3_ff);
      k1r2_4  = q_round(pk1_3_ff);
      a1_4_in = q_add(Q24_ONE, k1r2_4.val);
      b4_in   = b_ff[3] | r4_4_in.ovf | k1r2_4.ovf | a1_4_in.ovf;

      r6_6_in = q_round(pr6_5_ff);
      k2r4_6  = q_round(pk2_5_ff);
      a2_6_in = q_add(a1_5_ff, k2r4_6.val);
      b6_in   = b_ff[5] | r6_6_in.ovf | k2r4_6.ovf | a2_6_in.ovf;

      k3r6_8  = q_round(pk3_7_ff);
      rad8_in = q_add(a2_7_ff, k3r6_8.val);
      txa8_in = q_round(pxa7_ff);
      txb8_in = q_round(pxb7_ff);
      tya8_in = q_round(pya7_ff);
      tyb8_in = q_round(pyb7_ff);
      b8_in   = b_ff[7] | k3r6_8.ovf | rad8_in.ovf | txa8_in.ovf | txb8_in.ovf
              | tya8_in.ovf | tyb8_in.ovf;

      xr10    = q_round(px9_ff);
      yr10    = q_round(py9_ff);
      xs10    = q_add(xr10.val, txa9_ff);
      ys10    = q_add(yr10.val, tya9_ff);
      xd10_in = q_add(xs10.val, txb9_ff);
      yd10_in = q_add(ys10.val, tyb9_ff);
      b10_in  = b_ff[9] | xr10.ovf | yr10.ovf | xs10.ovf | ys10.ovf | xd10_in.ovf
              | yd10_in.ovf;
   end

   // pixel coordinates and bounds
   always_comb begin
      tu   = pu11_ff + 65'sd8388608;
      tv   = pv11_ff + 65'sd8388608;
      u12  = 42'(tu >>> 24) + 42'($signed({1'b0, cfg.center_x}));
      v12  = 42'(tv >>> 24) + 42'($signed({1'b0, cfg.center_y}));
      in12 = !b_ff[11] && !u12[41] && (u12 < U_LIM) && !v12[41] && (v12 < V_LIM);
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[10:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         b_ff[1]  <= in_bad;
         b_ff[2]  <= b2_in;
         b_ff[3]  <= b3_in;
         b_ff[4]  <= b4_in;
         b_ff[5]  <= b_ff[4];
         b_ff[6]  <= b6_in;
         b_ff[7]  <= b_ff[6];
         b_ff[8]  <= b8_in;
         b_ff[9]  <= b_ff[8];
         b_ff[10] <= b10_in;
         b_ff[11] <= b_ff[10];

         x1_ff   <= in_x;
         y1_ff   <= in_y;
         pxx1_ff <= in_x * in_x;
         pyy1_ff <= in_y * in_y;
         pxy1_ff <= in_x * in_y;

         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
         r2_2_ff <= r2_2_in.val;
         xyd2_ff <= xyd2_in.val;
         xxd2_ff <= xxd2_in.val;
         yyd2_ff <= yyd2_in.val;

         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         r2_3_ff  <= r2_2_ff;
         xyd3_ff  <= xyd2_ff;
         tx3_ff   <= tx3_in.val;
         ty3_ff   <= ty3_in.val;
         pr4_3_ff <= r2_2_ff * r2_2_ff;
         pk1_3_ff <= cfg.k1 * r2_2_ff;

         x4_ff   <= x3_ff;
         y4_ff   <= y3_ff;
         r2_4_ff <= r2_3_ff;
         r4_4_ff <= r4_4_in.val;
         xyd4_ff <= xyd3_ff;
         tx4_ff  <= tx3_ff;
         ty4_ff  <= ty3_ff;
         a1_4_ff <= a1_4_in.val;

         x5_ff    <= x4_ff;
         y5_ff    <= y4_ff;
         xyd5_ff  <= xyd4_ff;
         tx5_ff   <= tx4_ff;
         ty5_ff   <= ty4_ff;
         a1_5_ff  <= a1_4_ff;
         pr6_5_ff <= r4_4_ff * r2_4_ff;
         pk2_5_ff <= cfg.k2 * r4_4_ff;

         x6_ff   <= x5_ff;
         y6_ff   <= y5_ff;
         xyd6_ff <= xyd5_ff;
         tx6_ff  <= tx5_ff;
         ty6_ff  <= ty5_ff;
         a2_6_ff <= a2_6_in.val;
         r6_6_ff <= r6_6_in.val;

         x7_ff    <= x6_ff;
         y7_ff    <= y6_ff;
         a2_7_ff  <= a2_6_ff;
         pk3_7_ff <= cfg.k3 * r6_6_ff;
         pxa7_ff  <= cfg.p1 * xyd6_ff;
         pxb7_ff  <= cfg.p2 * tx6_ff;
         pya7_ff  <= cfg.p1 * ty6_ff;
         pyb7_ff  <= cfg.p2 * xyd6_ff;

         x8_ff   <= x7_ff;
         y8_ff   <= y7_ff;
         rad8_ff <= rad8_in.val;
         txa8_ff <= txa8_in.val;
         txb8_ff <= txb8_in.val;
         tya8_ff <= tya8_in.val;
         tyb8_ff <= tyb8_in.val;

         px9_ff  <= x8_ff * rad8_ff;
         py9_ff  <= y8_ff * rad8_ff;
         txa9_ff <= txa8_ff;
         txb9_ff <= txb8_ff;
         tya9_ff <= tya8_ff;
         tyb9_ff <= tyb8_ff;

         xd10_ff <= xd10_in.val;
         yd10_ff <= yd10_in.val;

         pu11_ff <= $signed({1'b0, cfg.focal_x}) * xd10_ff;
         pv11_ff <= $signed({1'b0, cfg.focal_y}) * yd10_ff;

         u12_ff  <= in12 ? u12[27:0] : 28'd0;
         v12_ff  <= in12 ? v12[27:0] : 28'd0;
         in12_ff <= in12;
      end
   end

   assign out_valid    = v_ff[11];
   assign out_u        = u12_ff;
   assign out_v        = v12_ff;
   assign out_in_image = in12_ff;

endmodule

### dv/bcp_checker.sv
// request/response scoreboard with a fixed-point projection predictor
`timescale 1ns / 100ps

module bcp_checker import bcp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_cam_x,
   input  logic signed [31:0] req_cam_y,
   input  logic signed [31:0] req_cam_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [27:0]        rsp_pixel_u,
   input  logic [27:0]        rsp_pixel_v,
   input  logic               rsp_in_image,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   input  logic               csr_pready,
   output int                 errors,
   output int                 pending,
   output int                 requests,
   output int                 hits
);

   typedef struct packed {
      logic [27:0] u;
      logic [27:0] v;
      logic        in_image;
   } pixel_type;

   localparam int WIDTH_Q16  = IMAGE_WIDTH_DEF * 65536;
   localparam int HEIGHT_Q16 = IMAGE_HEIGHT_DEF * 65536;

   cfg_type     cam_cfg;
   pixel_type   pixel_q[$];

   // saturate to signed 32 bits, noting overflow
   function automatic longint sat32(input longint v, inout bit o);
      if (v > 64'sd2147483647) begin
         o = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         o = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Q8.24 product rounded to nearest, ties up
   function automatic longint qmul(input longint a, input longint b, inout bit o);
      return sat32((a * b + 64'sd8388608) >>> 24, o);
   endfunction

   function automatic longint qsum(input longint a, input longint b, inout bit o);
      return sat32(a + b, o);
   endfunction

   // project one camera point to a pixel
   function automatic pixel_type project_point(input logic signed [31:0] cx,
                                               input logic signed [31:0] cy,
                                               input logic signed [31:0] cz);
      pixel_type r;
      bit o;
      longint x, y, xx, yy, xy, r2, r4, r6, rad, xd, yd, u, v;
      longint k1, k2, k3, p1, p2;
      r = '0;
      o = 1'b0;
      if (cz == 0) return r;
      k1 = cam_cfg.k1;
      k2 = cam_cfg.k2;
      k3 = cam_cfg.k3;
      p1 = cam_cfg.p1;
      p2 = cam_cfg.p2;
      x = sat32((longint'(cx) * 64'sd16777216) / longint'(cz), o);
      y = sat32((longint'(cy) * 64'sd16777216) / longint'(cz), o);
      xx = qmul(x, x, o);
      yy = qmul(y, y, o);
      xy = qmul(x, y, o);
      r2 = qsum(xx, yy, o);
      r4 = qmul(r2, r2, o);
      r6 = qmul(r4, r2, o);
      rad = qsum(qsum(qsum(64'sd16777216, qmul(k1, r2, o), o), qmul(k2, r4, o), o),
                 qmul(k3, r6, o), o);
      xd = qsum(qsum(qmul(x, rad, o), qmul(p1, qsum(xy, xy, o), o), o),
                qmul(p2, qsum(r2, qsum(xx, xx, o), o), o), o);
      yd = qsum(qsum(qmul(y, rad, o), qmul(p1, qsum(r2, qsum(yy, yy, o), o), o), o),
                qmul(p2, qsum(xy, xy, o), o), o);
      if (o) return r;
      u = ((longint'({32'b0, cam_cfg.focal_x}) * xd + 64'sd8388608) >>> 24)
          + longint'({32'b0, cam_cfg.center_x});
      v = ((longint'({32'b0, cam_cfg.focal_y}) * yd + 64'sd8388608) >>> 24)
          + longint'({32'b0, cam_cfg.center_y});
      if (u < 0 || u >= WIDTH_Q16 || v < 0 || v >= HEIGHT_Q16) return r;
      r.u = u[27:0];
      r.v = v[27:0];
      r.in_image = 1'b1;
      return r;
   endfunction

   assign pending = pixel_q.size();

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         cam_cfg.focal_x  <= FOCAL_X_RST;
         cam_cfg.focal_y  <= FOCAL_Y_RST;
         cam_cfg.center_x <= CENTER_X_RST;
         cam_cfg.center_y <= CENTER_Y_RST;
         cam_cfg.k1 <= '0;
         cam_cfg.k2 <= '0;
         cam_cfg.k3 <= '0;
         cam_cfg.p1 <= '0;
         cam_cfg.p2 <= '0;
         errors   <= 0;
         requests <= 0;
         hits     <= 0;
         pixel_q.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               REG_FOCAL_X:    cam_cfg.focal_x  <= csr_pwdata[31:0];
               REG_FOCAL_Y:    cam_cfg.focal_y  <= csr_pwdata[31:0];
               REG_CENTER_X:   cam_cfg.center_x <= csr_pwdata[31:0];
               REG_CENTER_Y:   cam_cfg.center_y <= csr_pwdata[31:0];
               REG_RADIAL_K1:  cam_cfg.k1 <= csr_pwdata[31:0];
               REG_RADIAL_K2:  cam_cfg.k2 <= csr_pwdata[31:0];
               REG_RADIAL_K3:  cam_cfg.k3 <= csr_pwdata[31:0];
               REG_TANGENTIAL: begin
                  cam_cfg.p1 <= csr_pwdata[31:0];
                  cam_cfg.p2 <= csr_pwdata[63:32];
               end
               default: ;
            endcase
         end
         // accepted request, queued at the tail
         if (req_valid && !req_stall) begin
            pixel_q.insert(pixel_q.size(), project_point(req_cam_x, req_cam_y, req_cam_z));
            requests <= requests + 1;
         end
         // accepted response
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected response u=%h v=%h in_image=%b", $time,
                        rsp_pixel_u, rsp_pixel_v, rsp_in_image);
               errors <= errors + 1;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_in_image) hits <= hits + 1;
               if (want.u !== rsp_pixel_u || want.v !== rsp_pixel_v ||
                   want.in_image !== rsp_in_image) begin
                  $display("%0t: mismatch expected u=%h v=%h in_image=%b actual u=%h v=%h in_image=%b",
                           $time, want.u, want.v, want.in_image,
                           rsp_pixel_u, rsp_pixel_v, rsp_in_image);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

### dv/tb_top.sv
// stimulus, register setup and verdict for the point projection block
`timescale 1ns / 100ps

module tb_top import bcp_pkg::*;;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_cam_x = '0;
   logic signed [31:0] req_cam_y = '0;
   logic signed [31:0] req_cam_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [27:0]        rsp_pixel_u;
   logic [27:0]        rsp_pixel_v;
   logic               rsp_in_image;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr = '0;
   logic [CSR_DW-1:0]  csr_pwdata = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;
   int                 errors, pending, requests, hits;

   always #5 clock = ~clock;

   brown_conrady_point_projection u_dut (.*);

   bcp_checker u_checker (.*);

   // write one register through a setup phase and an access phase
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 3'b000});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_camera(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] k1, input logic [31:0] k2,
                              input logic [31:0] k3, input logic [63:0] tan);
      csr_write(REG_FOCAL_X, {32'b0, fx});
      csr_write(REG_FOCAL_Y, {32'b0, fy});
      csr_write(REG_CENTER_X, {32'b0, cx});
      csr_write(REG_CENTER_Y, {32'b0, cy});
      csr_write(REG_RADIAL_K1, {32'b0, k1});
      csr_write(REG_RADIAL_K2, {32'b0, k2});
      csr_write(REG_RADIAL_K3, {32'b0, k3});
      csr_write(REG_TANGENTIAL, tan);
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // offer one request and hold it until taken
   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input int gap);
      req_valid <= 1'b1;
      req_cam_x <= x;
      req_cam_y <= y;
      req_cam_z <= z;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly points in front of the camera near the optical axis, some noise
   task automatic send_random(input int gap);
      longint depth, nx, ny;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
         depth = $urandom_range(1 << 14, 200 << 16);
         if (sel < 8) depth = -depth;
         nx = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
         ny = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
         send_point(32'((depth * nx) >>> 24), 32'((depth * ny) >>> 24),
                    32'(depth), gap);
      end else if (sel < 80) begin
         send_point($urandom, $urandom, 32'd0, gap);
      end else begin
         send_point($urandom, $urandom, $urandom, gap);
      end
   endtask

   // wait until every response is back and the pipe has drained
   task automatic drain();
      req_valid <= 1'b0;
      // let the checker queue the request taken at this edge first
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // receiver stalls, with one long hold-off while requests keep coming
   initial begin
      int n;
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && requests > 100) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
         end
         n = $urandom_range(0, 19);
         if (n == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            rsp_stall <= (n < 5);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("brown_conrady_point_projection regression: fail");
      $finish;
   end

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed points at reset settings
      send_point(32'd0, 32'd0, 32'h0001_0000, 0);              // principal point
      send_point(32'h0001_0000, 32'h0001_0000, 32'd0, 0);      // zero depth
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'd0, 1);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_point(32'h8000_0000, 32'd0, 32'hffff_ffff, 0);      // division overflow
      send_point(32'h7fff_ffff, 32'd0, 32'd1, 2);
      send_point(32'hffff_8000, 32'h0000_8000, 32'hffff_0000, 0); // negative depth
      send_point(32'h0000_f000, 32'h0000_8000, 32'h0001_0000, 0); // near right edge
      send_point(32'hffff_0e00, 32'hffff_7600, 32'h0001_0000, 0); // near top-left
      send_point(32'h0002_0000, 32'd0, 32'h0001_0000, 0);      // off the image
      send_point(32'd0, 32'h0002_0000, 32'h0001_0000, 0);
      send_point(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 0);
      send_point(32'd1, 32'd1, 32'h7fff_ffff, 3);
      drain();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: load_camera(32'd65536000, 32'd62914560, 32'd62914560, 32'd35389440,
                           -32'sd3355443, 32'sd838861, 32'sd167772,
                           {32'hfffd_f3b6, 32'h0000_4189});
            2: load_camera(32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0,
                           32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                           {32'h8000_0000, 32'h7fff_ffff});
            3: load_camera(32'd0, 32'd0, 32'hffff_ffff, 32'hffff_ffff,
                           32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                           {32'h7fff_ffff, 32'h8000_0000});
            4: load_camera($urandom_range(100, 3000) << 16, $urandom_range(100, 3000) << 16,
                           $urandom_range(0, 1919) << 16, $urandom_range(0, 1079) << 16,
                           $urandom_range(0, 1 << 23) - (1 << 22),
                           $urandom_range(0, 1 << 22) - (1 << 21),
                           $urandom_range(0, 1 << 21) - (1 << 20),
                           {$urandom, $urandom});
            default: load_camera(32'd65536000, 32'd65536000, 32'd62914560, 32'd35389440,
                                 32'd0, 32'd0, 32'd0, 64'd0);
         endcase
         repeat (90) send_random((phase == 0) ? 0 : pick_gap());
         drain();
      end

      $display("%0d points projected over six camera settings, %0d inside the image",
               requests, hits);
      if (errors == 0)
         $display("brown_conrady_point_projection regression: pass");
      else
         $display("brown_conrady_point_projection regression: fail");
      $finish;
   end

endmodule
